>>> rtl/rvx_pkg.sv
`default_nettype none

package rvx_pkg;

  // Data memory size in bytes; a power of two, kept as four byte-wide banks.
  localparam int DATA_BYTES = 1024;
  localparam int ROWS = DATA_BYTES / 4;
  localparam int ROW_W = $clog2(ROWS);

  typedef logic [ROW_W-1:0] row_t;

  localparam logic [31:0] SP_RESET = 32'h7FFF_FFF0;
  localparam logic [4:0] ZERO_REG = 5'd0;
  localparam logic [4:0] SP_REG = 5'd2;

  localparam logic [6:0] OP_R = 7'b0110011;
  localparam logic [6:0] OP_I = 7'b0010011;
  localparam logic [6:0] OP_B = 7'b1100011;
  localparam logic [6:0] OP_JAL = 7'b1101111;
  localparam logic [6:0] OP_JALR = 7'b1100111;
  localparam logic [6:0] OP_LOAD = 7'b0000011;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT = 7'b0100000;

  localparam logic [2:0] LD_B = 3'd0;
  localparam logic [2:0] LD_H = 3'd1;
  localparam logic [2:0] LD_W = 3'd2;
  localparam logic [2:0] LD_BU = 3'd4;
  localparam logic [2:0] LD_HU = 3'd5;

  localparam logic [1:0] ST_EXEC = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_PRELOAD = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic writes;
    logic taken;
    logic is_load;
    logic [2:0] f3;
    logic [31:0] next_pc;
    logic [31:0] result;
    logic [31:0] addr;
  } exec_t;

endpackage

`default_nettype wire

>>> rtl/rvx_ram.sv
`default_nettype none

module rvx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read and a write to the same address in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rvx_exec.sv
`default_nettype none

module rvx_exec (
  input  logic [31:0]    instr,
  input  logic [31:0]    pc,
  input  logic [31:0]    rs1_value,
  input  logic [31:0]    rs2_value,
  output rvx_pkg::exec_t ex
);

  localparam logic [2:0] BR_EQ = 3'd0;
  localparam logic [2:0] BR_NE = 3'd1;
  localparam logic [2:0] BR_LT = 3'd4;
  localparam logic [2:0] BR_GE = 3'd5;
  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SLT = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_SR = 3'd5;
  localparam logic [2:0] F3_OR = 3'd6;
  localparam logic [2:0] F3_JALR = 3'd0;

  logic [6:0] op;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [6:0] f7a;
  logic reg_form;
  logic is_shift;
  logic [31:0] immi;
  logic [31:0] immb;
  logic [31:0] immj;
  logic [31:0] opb;
  logic [31:0] pc4;
  logic [31:0] addr_sum;
  logic alu_ok;
  logic [31:0] alu_res;
  logic br_eq;
  logic br_lt;

  assign op = instr[6:0];
  assign f3 = instr[14:12];
  assign f7 = instr[31:25];
  assign reg_form = (op == rvx_pkg::OP_R);
  assign is_shift = (f3 == F3_SLL) || (f3 == F3_SR);
  assign f7a = (reg_form || is_shift) ? f7 : rvx_pkg::F7_BASE;

  assign immi = {{20{instr[31]}}, instr[31:20]};
  assign immb = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign immj = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign opb = reg_form ? rs2_value : (is_shift ? {27'b0, instr[24:20]} : immi);

  assign pc4 = pc + 32'd4;
  assign addr_sum = rs1_value + immi;
  assign br_eq = (rs1_value == rs2_value);
  assign br_lt = ($signed(rs1_value) < $signed(rs2_value));

  always_comb begin
    alu_ok = 1'b1;
    alu_res = '0;
    unique case (f3)
      F3_ADD: begin
        if (!reg_form || f7a == rvx_pkg::F7_BASE) begin
          alu_res = rs1_value + opb;
        end else if (f7a == rvx_pkg::F7_ALT) begin
          alu_res = rs1_value - opb;
        end else begin
          alu_ok = 1'b0;
        end
      end
      F3_SLL: begin
        alu_ok = (f7a == rvx_pkg::F7_BASE);
        alu_res = rs1_value << opb[4:0];
      end
      F3_SLT: begin
        alu_ok = (f7a == rvx_pkg::F7_BASE);
        alu_res = {31'b0, $signed(rs1_value) < $signed(opb)};
      end
      F3_SLTU: begin
        alu_ok = (f7a == rvx_pkg::F7_BASE);
        alu_res = {31'b0, rs1_value < opb};
      end
      F3_XOR: begin
        alu_ok = (f7a == rvx_pkg::F7_BASE);
        alu_res = rs1_value ^ opb;
      end
      F3_SR: begin
        if (f7a == rvx_pkg::F7_BASE) begin
          alu_res = rs1_value >> opb[4:0];
        end else if (f7a == rvx_pkg::F7_ALT) begin
          alu_res = $unsigned($signed(rs1_value) >>> opb[4:0]);
        end else begin
          alu_ok = 1'b0;
        end
      end
      F3_OR: begin
        alu_ok = (f7a == rvx_pkg::F7_BASE);
        alu_res = rs1_value | opb;
      end
      default: begin
        alu_ok = (f7a == rvx_pkg::F7_BASE);
        alu_res = rs1_value & opb;
      end
    endcase
  end

  always_comb begin
    ex = '0;
    ex.status = rvx_pkg::ST_EXEC;
    ex.next_pc = pc4;
    ex.f3 = f3;
    ex.addr = addr_sum;
    unique case (op)
      rvx_pkg::OP_R, rvx_pkg::OP_I: begin
        ex.writes = alu_ok;
        ex.result = alu_res;
        if (!alu_ok) begin
          ex.status = rvx_pkg::ST_UNSUP;
        end
      end
      rvx_pkg::OP_B: begin
        unique case (f3)
          BR_EQ: ex.taken = br_eq;
          BR_NE: ex.taken = !br_eq;
          BR_LT: ex.taken = br_lt;
          BR_GE: ex.taken = !br_lt;
          default: ex.status = rvx_pkg::ST_UNSUP;
        endcase
        if (ex.taken) begin
          ex.next_pc = pc + immb;
        end
      end
      rvx_pkg::OP_JAL: begin
        ex.writes = 1'b1;
        ex.taken = 1'b1;
        ex.result = pc4;
        ex.next_pc = pc + immj;
      end
      rvx_pkg::OP_JALR: begin
        if (f3 == F3_JALR) begin
          ex.writes = 1'b1;
          ex.taken = 1'b1;
          ex.result = pc4;
          ex.next_pc = {addr_sum[31:1], 1'b0};
        end else begin
          ex.status = rvx_pkg::ST_UNSUP;
        end
      end
      rvx_pkg::OP_LOAD: begin
        if (f3 inside {rvx_pkg::LD_B, rvx_pkg::LD_H, rvx_pkg::LD_W,
                       rvx_pkg::LD_BU, rvx_pkg::LD_HU}) begin
          ex.writes = 1'b1;
          ex.is_load = 1'b1;
        end else begin
          ex.status = rvx_pkg::ST_UNSUP;
        end
      end
      default: ex.status = rvx_pkg::ST_UNSUP;
    endcase
    if (ex.status == rvx_pkg::ST_UNSUP) begin
      ex.writes = 1'b0;
      ex.taken = 1'b0;
      ex.is_load = 1'b0;
      ex.result = '0;
      ex.next_pc = pc4;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rv32i_subset_execute.sv
// Executes a subset of RV32I, one instruction word or one data preload per beat.
// Input channel: in_valid/in_stall with action, instruction_word (executed at the
// current pc), preload_word_index and preload_value (one little-endian data word).
// Output channel: out_valid/out_stall with one result beat per input beat, in order:
// executed_pc, next_pc, dest_reg, write_value, write_enable, branch_taken, status.
// An input beat is held in the execute register until the result register is
// free, and its result is shown from the result register. Throughput is one beat
// per clock while out_stall is low; the register file and the four data memory
// byte banks are each read once per beat, and the result register and the most
// recent register write are forwarded into execute.
// Reset (rst, synchronous) sets the pc to zero, the register file to zero with sp
// at 0x7FFFFFF0, and the data memory to zero. Both are cleared through per-entry
// valid flags, so no clearing pass is needed and a beat is taken right after reset.
// While out_stall is high the result holds; one more beat is still taken into
// execute, after which in_stall rises until the result beat moves on.
`default_nettype none

module rv32i_subset_execute (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] instruction_word,
  input  logic [7:0]  preload_word_index,
  input  logic [31:0] preload_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] executed_pc,
  output logic [31:0] next_pc,
  output logic [4:0]  dest_reg,
  output logic [31:0] write_value,
  output logic        write_enable,
  output logic        branch_taken,
  output logic [1:0]  status
);

  logic in_acc;
  logic out_acc;
  logic b_free;
  logic a_adv;

  logic a_valid;
  logic a_action;
  logic [31:0] a_instr;
  logic [7:0] a_pidx;
  logic [31:0] a_pval;
  logic [31:0] pc;

  logic [31:0] rf_valid;
  logic [31:0] rs_ram [2];
  logic [4:0] rs_idx [2];
  logic [31:0] rs_val [2];
  logic ret_valid;
  logic [4:0] ret_rd;
  logic [31:0] ret_value;

  rvx_pkg::exec_t ex;

  logic b_valid;
  logic [31:0] b_pc;
  logic [31:0] b_next;
  logic [4:0] b_dest;
  logic b_we;
  logic b_taken;
  logic [1:0] b_status;
  logic [31:0] b_res;
  logic b_load;
  logic [2:0] b_f3;
  logic [1:0] b_off;
  logic [3:0] b_rvalid;

  logic [rvx_pkg::ROWS-1:0] row_valid;
  rvx_pkg::row_t pre_row;
  rvx_pkg::row_t base_row;
  rvx_pkg::row_t bank_raddr [4];
  logic [1:0] ld_off;
  logic [7:0] bank_rd [4];
  logic [7:0] bk [4];
  logic [7:0] lb [4];
  logic [31:0] load_val;
  logic [31:0] wval;

  assign b_free = !b_valid || !out_stall;
  assign a_adv = a_valid && b_free;
  assign in_stall = a_valid && !b_free;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = b_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_acc) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_action <= action;
      a_instr <= instruction_word;
      a_pidx <= preload_word_index;
      a_pval <= preload_value;
    end
  end

  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(out_acc && b_we), .waddr(b_dest), .wdata(wval),
    .re(in_acc), .raddr(instruction_word[19:15]), .rdata(rs_ram[0])
  );

  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(out_acc && b_we), .waddr(b_dest), .wdata(wval),
    .re(in_acc), .raddr(instruction_word[24:20]), .rdata(rs_ram[1])
  );

  assign rs_idx[0] = a_instr[19:15];
  assign rs_idx[1] = a_instr[24:20];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (rs_idx[k] == rvx_pkg::ZERO_REG) begin
        rs_val[k] = '0;
      end else if (b_valid && b_we && b_dest == rs_idx[k]) begin
        rs_val[k] = wval;
      end else if (ret_valid && ret_rd == rs_idx[k]) begin
        rs_val[k] = ret_value;
      end else if (rf_valid[rs_idx[k]]) begin
        rs_val[k] = rs_ram[k];
      end else if (rs_idx[k] == rvx_pkg::SP_REG) begin
        rs_val[k] = rvx_pkg::SP_RESET;
      end else begin
        rs_val[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      ret_valid <= 1'b0;
    end else if (out_acc && b_we) begin
      rf_valid[b_dest] <= 1'b1;
      ret_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc && b_we) begin
      ret_rd <= b_dest;
      ret_value <= wval;
    end
  end

  rvx_exec u_exec (
    .instr(a_instr),
    .pc(pc),
    .rs1_value(rs_val[0]),
    .rs2_value(rs_val[1]),
    .ex(ex)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (a_adv && !a_action) begin
      pc <= ex.next_pc;
    end
  end

  assign pre_row = rvx_pkg::row_t'(32'(a_pidx));
  assign base_row = rvx_pkg::row_t'(ex.addr >> 2);
  assign ld_off = ex.addr[1:0];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      bank_raddr[j] = (2'(j) >= ld_off) ? base_row : base_row + rvx_pkg::row_t'(1);
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_bank
    rvx_ram #(.WIDTH(8), .DEPTH(rvx_pkg::ROWS)) u_bank (
      .clk(clk), .we(a_adv && a_action), .waddr(pre_row), .wdata(a_pval[8*j +: 8]),
      .re(a_adv), .raddr(bank_raddr[j]), .rdata(bank_rd[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (a_adv && a_action) begin
      row_valid[pre_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_adv) begin
      b_valid <= 1'b1;
    end else if (out_acc) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_pc <= pc;
      b_f3 <= ex.f3;
      b_off <= ld_off;
      for (int j = 0; j < 4; j++) begin
        b_rvalid[j] <= row_valid[bank_raddr[j]];
      end
      if (a_action) begin
        b_next <= pc;
        b_dest <= '0;
        b_we <= 1'b0;
        b_taken <= 1'b0;
        b_status <= rvx_pkg::ST_PRELOAD;
        b_res <= '0;
        b_load <= 1'b0;
      end else begin
        b_next <= ex.next_pc;
        b_dest <= ex.writes ? a_instr[11:7] : rvx_pkg::ZERO_REG;
        b_we <= ex.writes && (a_instr[11:7] != rvx_pkg::ZERO_REG);
        b_taken <= ex.taken;
        b_status <= ex.status;
        b_res <= ex.result;
        b_load <= ex.is_load;
      end
    end
  end

  // Bytes of a row that was never preloaded read as zero.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      bk[j] = b_rvalid[j] ? bank_rd[j] : 8'h00;
    end
    for (int k = 0; k < 4; k++) begin
      lb[k] = bk[2'(b_off + 2'(k))];
    end
    case (b_f3)
      rvx_pkg::LD_B: load_val = {{24{lb[0][7]}}, lb[0]};
      rvx_pkg::LD_H: load_val = {{16{lb[1][7]}}, lb[1], lb[0]};
      rvx_pkg::LD_W: load_val = {lb[3], lb[2], lb[1], lb[0]};
      rvx_pkg::LD_BU: load_val = {24'b0, lb[0]};
      rvx_pkg::LD_HU: load_val = {16'b0, lb[1], lb[0]};
      default: load_val = '0;
    endcase
  end

  assign wval = !b_we ? '0 : (b_load ? load_val : b_res);

  assign out_valid = b_valid;
  assign executed_pc = b_pc;
  assign next_pc = b_next;
  assign dest_reg = b_dest;
  assign write_value = wval;
  assign write_enable = b_we;
  assign branch_taken = b_taken;
  assign status = b_status;

  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> dest_reg != rvx_pkg::ZERO_REG)
    else $error("register write reported for x0");

  a_preload_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rvx_pkg::ST_PRELOAD |->
      next_pc == executed_pc && !write_enable && !branch_taken)
    else $error("preload result moved the pc or reported a write");

  a_unsup_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rvx_pkg::ST_UNSUP |->
      next_pc == executed_pc + 32'd4 && !write_enable && !branch_taken)
    else $error("unsupported instruction did not fall through");

  a_quiet_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> write_value == '0)
    else $error("write value shown without a register write");

  a_pc_chain: assert property (@(posedge clk) disable iff (rst)
    out_acc && a_adv |=> executed_pc == $past(next_pc))
    else $error("next beat did not start at the previous next pc");

endmodule

`default_nettype wire
